/* design/ppst_pkg.sv */
package ppst_pkg;

    localparam int ENT_W   = 12;
    localparam int SLOT_W  = 10;
    localparam int COUNT_W = 11;
    localparam int PAY_W   = 64;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_SET    = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;
    localparam logic [1:0] ST_DUP     = 2'd3;

    localparam logic KIND_RELOC = 1'b0;
    localparam logic KIND_DONE  = 1'b1;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [ENT_W-1:0]   entity_id;
        logic               sleeping;
        logic [PAY_W-1:0]   payload;
    } t_cmd;

    typedef struct packed {
        logic               kind;
        logic [ENT_W-1:0]   moved_entity;
        logic [SLOT_W-1:0]  from_slot;
        logic [SLOT_W-1:0]  to_slot;
        logic [PAY_W-1:0]   moved_payload;
        logic [1:0]         status;
        logic [COUNT_W-1:0] entry_count;
        logic [COUNT_W-1:0] awake_count;
        logic               last;
    } t_res;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_LOOK, S_DEC, S_RDP,
        S_M1A, S_M1B, S_M2A, S_M2B, S_PLACE, S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic clr;
        logic look;
        logic dec;
        logic rdp;
        logic m1a;
        logic m1b;
        logic m2a;
        logic m2b;
        logic place;
        logic done;
    } t_ctl;

    typedef struct packed {
        logic clr_last;
        logic rdp;
        logic m1;
        logic m2;
        logic place;
    } t_stat;

endpackage

/* design/ppst_ctrl.sv */
module ppst_ctrl import ppst_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    input  t_stat i_stat,
    output t_ctl  o_ctl,
    output logic  busy
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR:   if (i_stat.clr_last) n_state = S_IDLE;
            S_IDLE:  if (start) n_state = S_LOOK;
            S_LOOK:  n_state = S_DEC;
            S_DEC: begin
                if (i_stat.rdp)        n_state = S_RDP;
                else if (i_stat.m1)    n_state = S_M1A;
                else if (i_stat.place) n_state = S_PLACE;
                else                   n_state = S_DONE;
            end
            S_RDP: begin
                if (i_stat.m1)         n_state = S_M1A;
                else if (i_stat.m2)    n_state = S_M2A;
                else if (i_stat.place) n_state = S_PLACE;
                else                   n_state = S_DONE;
            end
            S_M1A:   n_state = S_M1B;
            S_M1B: begin
                if (i_stat.m2)         n_state = S_M2A;
                else if (i_stat.place) n_state = S_PLACE;
                else                   n_state = S_DONE;
            end
            S_M2A:   n_state = S_M2B;
            S_M2B: begin
                if (i_stat.place)      n_state = S_PLACE;
                else                   n_state = S_DONE;
            end
            S_PLACE: n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl       = '0;
        o_ctl.load  = (r_state == S_IDLE) && start;
        o_ctl.clr   = (r_state == S_CLR);
        o_ctl.look  = (r_state == S_LOOK);
        o_ctl.dec   = (r_state == S_DEC);
        o_ctl.rdp   = (r_state == S_RDP);
        o_ctl.m1a   = (r_state == S_M1A);
        o_ctl.m1b   = (r_state == S_M1B);
        o_ctl.m2a   = (r_state == S_M2A);
        o_ctl.m2b   = (r_state == S_M2B);
        o_ctl.place = (r_state == S_PLACE);
        o_ctl.done  = (r_state == S_DONE);
        busy        = (r_state != S_IDLE);
    end

endmodule

/* design/ppst_dp.sv */
module ppst_dp import ppst_pkg::*; #(
    parameter int SLOTS        = 1024,
    parameter int ENTITY_IDS   = 4096,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cmd  i_cmd,
    input  t_ctl  i_ctl,
    output t_stat o_stat,
    output logic  o_valid,
    output t_res  o_res
);

    localparam int SW  = $clog2(SLOTS);
    localparam int CW  = $clog2(SLOTS + 1);
    localparam int EW  = $clog2(ENTITY_IDS);
    localparam int SMW = EW + PAYLOAD_BITS;
    localparam int EMW = 1 + SW;

    // Slot memory holds {entity, payload}; entity map holds {valid, slot}.
    logic [SMW-1:0] sm_mem [SLOTS];
    logic [EMW-1:0] em_mem [ENTITY_IDS];
    logic [SMW-1:0] sm_rd, sm_wd;
    logic [EMW-1:0] em_rd, em_wd;
    logic [SW-1:0]  sm_addr;
    logic [EW-1:0]  em_addr;
    logic           sm_we, em_we;

    logic [1:0]              r_op;
    logic [ENT_W-1:0]        r_id;
    logic                    r_slp;
    logic [PAYLOAD_BITS-1:0] r_pay;
    logic [CW-1:0]           r_cnt, r_bnd;
    logic [EW-1:0]           r_clr;
    logic [PAYLOAD_BITS-1:0] r_p;
    logic                    r_capp;

    logic          r_rdp, r_inval, r_m1, r_m2, r_place, r_prec, r_pay_p, r_dp_in, r_dp_p;
    logic [SW-1:0] r_idx, r_m1s, r_m1d, r_m2s, r_m2d, r_pdst, r_dto;
    logic [1:0]    r_st;

    logic          d_rdp, d_inval, d_m1, d_m2, d_place, d_prec, d_pay_p, d_dp_in, d_dp_p;
    logic [SW-1:0] d_m1s, d_m1d, d_m2s, d_m2d, d_pdst, d_dto;
    logic [1:0]    d_st;
    logic [CW-1:0] d_cnt, d_bnd, idx_c, cm1, bm1;
    logic          in_rng, known;
    logic [SW-1:0] idx;

    logic [EW-1:0]           sm_ent;
    logic [PAYLOAD_BITS-1:0] sm_pay, p_now;

    logic n_valid;
    t_res n_res;

    assign sm_ent = sm_rd[SMW-1:PAYLOAD_BITS];
    assign sm_pay = sm_rd[PAYLOAD_BITS-1:0];
    assign p_now  = r_capp ? sm_pay : r_p;

    always_ff @(posedge i_clk) begin
        if (sm_we) begin
            sm_mem[sm_addr] <= sm_wd;
        end
        sm_rd <= sm_mem[sm_addr];
    end

    always_ff @(posedge i_clk) begin
        if (em_we) begin
            em_mem[em_addr] <= em_wd;
        end
        em_rd <= em_mem[em_addr];
    end

    always_comb begin
        em_addr = EW'(r_id);
        em_we   = 1'b0;
        em_wd   = '0;
        if (i_ctl.clr) begin
            em_addr = r_clr;
            em_we   = 1'b1;
        end else if (i_ctl.rdp) begin
            em_we   = r_inval;
        end else if (i_ctl.m1b || i_ctl.m2b) begin
            em_addr = sm_ent;
            em_we   = 1'b1;
            em_wd   = {1'b1, (i_ctl.m1b ? r_m1d : r_m2d)};
        end else if (i_ctl.place) begin
            em_we   = 1'b1;
            em_wd   = {1'b1, r_pdst};
        end
    end

    always_comb begin
        sm_addr = r_idx;
        sm_we   = 1'b0;
        sm_wd   = sm_rd;
        if (i_ctl.m1a) begin
            sm_addr = r_m1s;
        end else if (i_ctl.m1b) begin
            sm_addr = r_m1d;
            sm_we   = 1'b1;
        end else if (i_ctl.m2a) begin
            sm_addr = r_m2s;
        end else if (i_ctl.m2b) begin
            sm_addr = r_m2d;
            sm_we   = 1'b1;
        end else if (i_ctl.place) begin
            sm_addr = r_pdst;
            sm_we   = 1'b1;
            sm_wd   = {EW'(r_id), (r_pay_p ? p_now : r_pay)};
        end
    end

    // Plan of the whole operation, worked out from the map lookup.
    always_comb begin
        in_rng  = (32'(r_id) < ENTITY_IDS);
        known   = in_rng && em_rd[EMW-1];
        idx     = em_rd[SW-1:0];
        idx_c   = CW'(idx);
        cm1     = r_cnt - CW'(1);
        bm1     = r_bnd - CW'(1);
        d_rdp   = 1'b0;
        d_inval = 1'b0;
        d_m1    = 1'b0;
        d_m2    = 1'b0;
        d_place = 1'b0;
        d_prec  = 1'b0;
        d_pay_p = 1'b0;
        d_dp_in = 1'b0;
        d_dp_p  = 1'b0;
        d_m1s   = '0;
        d_m1d   = '0;
        d_m2s   = '0;
        d_m2d   = '0;
        d_pdst  = '0;
        d_dto   = '0;
        d_st    = ST_OK;
        d_cnt   = r_cnt;
        d_bnd   = r_bnd;
        if (!in_rng && r_op != OP_NONE) begin
            d_st = ST_UNKNOWN;
        end else begin
            case (r_op)
                OP_ADD: begin
                    if (known) begin
                        d_st = ST_DUP;
                    end else if (r_cnt == CW'(SLOTS)) begin
                        d_st = ST_FULL;
                    end else begin
                        d_place = 1'b1;
                        d_dp_in = 1'b1;
                        d_cnt   = r_cnt + CW'(1);
                        if (r_slp) begin
                            d_pdst = SW'(r_cnt);
                        end else begin
                            // An awake add pushes the first sleeper to the end.
                            if (r_bnd != r_cnt) begin
                                d_m1  = 1'b1;
                                d_m1s = SW'(r_bnd);
                                d_m1d = SW'(r_cnt);
                            end
                            d_pdst = SW'(r_bnd);
                            d_bnd  = r_bnd + CW'(1);
                        end
                        d_dto = d_pdst;
                    end
                end
                OP_REMOVE: begin
                    if (!known) begin
                        d_st = ST_UNKNOWN;
                    end else begin
                        d_rdp   = 1'b1;
                        d_inval = 1'b1;
                        d_dp_p  = 1'b1;
                        d_dto   = idx;
                        d_cnt   = cm1;
                        if (idx_c >= r_bnd) begin
                            if (idx_c != cm1) begin
                                d_m1  = 1'b1;
                                d_m1s = SW'(cm1);
                                d_m1d = idx;
                            end
                        end else begin
                            if (idx_c != bm1) begin
                                d_m1  = 1'b1;
                                d_m1s = SW'(bm1);
                                d_m1d = idx;
                            end
                            if (r_bnd != r_cnt) begin
                                d_m2  = 1'b1;
                                d_m2s = SW'(cm1);
                                d_m2d = SW'(bm1);
                            end
                            d_bnd = bm1;
                        end
                    end
                end
                OP_SET: begin
                    if (!known) begin
                        d_st = ST_UNKNOWN;
                    end else begin
                        d_rdp  = 1'b1;
                        d_dp_p = 1'b1;
                        d_dto  = idx;
                        if (!r_slp && idx_c >= r_bnd) begin
                            d_dto = SW'(r_bnd);
                            d_bnd = r_bnd + CW'(1);
                        end else if (r_slp && idx_c < r_bnd) begin
                            d_dto = SW'(bm1);
                            d_bnd = bm1;
                        end
                        if (d_dto != idx) begin
                            d_m1    = 1'b1;
                            d_m1s   = d_dto;
                            d_m1d   = idx;
                            d_place = 1'b1;
                            d_prec  = 1'b1;
                            d_pay_p = 1'b1;
                            d_pdst  = d_dto;
                        end
                    end
                end
                default: begin
                    d_st = ST_OK;
                end
            endcase
        end
    end

    always_comb begin
        o_stat.clr_last = (r_clr == EW'(ENTITY_IDS - 1));
        o_stat.rdp      = i_ctl.dec ? d_rdp   : r_rdp;
        o_stat.m1       = i_ctl.dec ? d_m1    : r_m1;
        o_stat.m2       = i_ctl.dec ? d_m2    : r_m2;
        o_stat.place    = i_ctl.dec ? d_place : r_place;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_bnd   <= '0;
            r_clr   <= '0;
            r_capp  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (i_ctl.clr) begin
                r_clr <= r_clr + EW'(1);
            end
            if (i_ctl.dec) begin
                r_cnt <= d_cnt;
                r_bnd <= d_bnd;
            end
            r_capp  <= i_ctl.rdp;
            o_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_op  <= i_cmd.opcode;
            r_id  <= i_cmd.entity_id;
            r_slp <= i_cmd.sleeping;
            r_pay <= PAYLOAD_BITS'(i_cmd.payload);
        end
        if (r_capp) begin
            r_p <= sm_pay;
        end
        if (i_ctl.dec) begin
            r_idx   <= idx;
            r_rdp   <= d_rdp;
            r_inval <= d_inval;
            r_m1    <= d_m1;
            r_m2    <= d_m2;
            r_place <= d_place;
            r_prec  <= d_prec;
            r_pay_p <= d_pay_p;
            r_dp_in <= d_dp_in;
            r_dp_p  <= d_dp_p;
            r_m1s   <= d_m1s;
            r_m1d   <= d_m1d;
            r_m2s   <= d_m2s;
            r_m2d   <= d_m2d;
            r_pdst  <= d_pdst;
            r_dto   <= d_dto;
            r_st    <= d_st;
        end
        o_res <= n_res;
    end

    always_comb begin
        n_valid             = 1'b0;
        n_res.kind          = KIND_RELOC;
        n_res.moved_entity  = ENT_W'(sm_ent);
        n_res.from_slot     = SLOT_W'(i_ctl.m1b ? r_m1s : r_m2s);
        n_res.to_slot       = SLOT_W'(i_ctl.m1b ? r_m1d : r_m2d);
        n_res.moved_payload = PAY_W'(sm_pay);
        n_res.status        = ST_OK;
        n_res.entry_count   = COUNT_W'(r_cnt);
        n_res.awake_count   = COUNT_W'(r_bnd);
        n_res.last          = 1'b0;
        if (i_ctl.m1b || i_ctl.m2b) begin
            n_valid = 1'b1;
        end else if (i_ctl.place) begin
            n_valid             = r_prec;
            n_res.moved_entity  = r_id;
            n_res.from_slot     = SLOT_W'(r_idx);
            n_res.to_slot       = SLOT_W'(r_pdst);
            n_res.moved_payload = PAY_W'(p_now);
        end else if (i_ctl.done) begin
            n_valid             = 1'b1;
            n_res.kind          = KIND_DONE;
            n_res.moved_entity  = r_id;
            n_res.from_slot     = '0;
            n_res.to_slot       = SLOT_W'(r_dto);
            n_res.moved_payload = r_dp_in ? PAY_W'(r_pay) :
                                  (r_dp_p ? PAY_W'(p_now) : '0);
            n_res.status        = r_st;
            n_res.last          = 1'b1;
        end
    end

endmodule

/* design/partitioned_packed_slot_table_top.sv */
// Channel   Direction  Handshake                 Payload
// command   in         start high, busy low      i_cmd  (t_cmd)
// result    out        o_valid strobe, 1 cycle   o_res  (t_res)
//
// From accept until busy falls an operation runs a map lookup and a decode step,
// then one access of the slot memory's single port per step (payload read, a
// read and a write per entry move, one placement) and ends with the done beat.
// After reset the entity map is cleared, one entry a cycle, with busy high until all
// ENTITY_IDS entries are clear. Each result beat stands for one cycle after the
// cycle that produced it; the receiver cannot stall, so no beat is ever held.
module partitioned_packed_slot_table_top import ppst_pkg::*; #(
    parameter int SLOTS        = 1024,
    parameter int ENTITY_IDS   = 4096,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_cmd i_cmd,
    output logic o_valid,
    output t_res o_res
);

    t_ctl  ctl;
    t_stat stat;

    ppst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_ctl   (ctl),
        .busy    (busy)
    );

    ppst_dp #(
        .SLOTS        (SLOTS),
        .ENTITY_IDS   (ENTITY_IDS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .i_ctl   (ctl),
        .o_stat  (stat),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

endmodule

/* sim/partitioned_packed_slot_table_checker.sv */
`timescale 1ns / 100ps

module partitioned_packed_slot_table_checker import ppst_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   start,
    input  logic   busy,
    input  t_cmd   i_cmd,
    input  logic   o_valid,
    input  t_res   o_res,
    output int     fail_count,
    output int     pending_count
);

    localparam int SLOTS      = 1024;
    localparam int ENTITY_IDS = 4096;

    logic [ENT_W-1:0]   tbl_entity [SLOTS];
    logic [PAY_W-1:0]   tbl_payload [SLOTS];
    logic [SLOT_W-1:0]  ent_slot [ENTITY_IDS];
    logic               ent_live [ENTITY_IDS];
    int                 occupied;
    int                 boundary;

    t_res               expected_beats [$];
    t_res               op_beats [$];

    assign pending_count = expected_beats.size();

    task automatic report_mismatch(input string what, input t_res got, input t_res want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic void push_beat(input logic kind, input logic [ENT_W-1:0] ent,
                                      input int from, input int to,
                                      input logic [PAY_W-1:0] pay, input logic [1:0] st);
        t_res r;
        r = '0;
        r.kind = kind;
        r.moved_entity = ent;
        r.from_slot = from[SLOT_W-1:0];
        r.to_slot = to[SLOT_W-1:0];
        r.moved_payload = pay;
        r.status = st;
        op_beats.push_back(r);
    endfunction

    function automatic void put_entry(input logic [ENT_W-1:0] ent,
                                      input logic [PAY_W-1:0] pay, input int dst);
        tbl_entity[dst] = ent;
        tbl_payload[dst] = pay;
        ent_slot[ent] = dst[SLOT_W-1:0];
    endfunction

    function automatic void shift_entry(input int src, input int dst);
        logic [ENT_W-1:0] ent;
        logic [PAY_W-1:0] pay;
        ent = tbl_entity[src];
        pay = tbl_payload[src];
        put_entry(ent, pay, dst);
        push_beat(KIND_RELOC, ent, src, dst, pay, ST_OK);
    endfunction

    function automatic void apply_command(input t_cmd c);
        logic [ENT_W-1:0] e;
        logic [PAY_W-1:0] p;
        logic             known;
        int               idx;
        int               fin;
        int               dst;
        e = c.entity_id;
        known = ent_live[e];
        op_beats.delete();
        if (c.opcode == OP_NONE) begin
            push_beat(KIND_DONE, e, 0, 0, '0, ST_OK);
        end else if (c.opcode == OP_ADD) begin
            if (known) begin
                push_beat(KIND_DONE, e, 0, 0, '0, ST_DUP);
            end else if (occupied >= SLOTS) begin
                push_beat(KIND_DONE, e, 0, 0, '0, ST_FULL);
            end else begin
                if (c.sleeping) begin
                    dst = occupied;
                end else begin
                    if (boundary != occupied) shift_entry(boundary, occupied);
                    dst = boundary;
                    boundary++;
                end
                put_entry(e, c.payload, dst);
                ent_live[e] = 1'b1;
                occupied++;
                push_beat(KIND_DONE, e, 0, dst, c.payload, ST_OK);
            end
        end else if (!known) begin
            push_beat(KIND_DONE, e, 0, 0, '0, ST_UNKNOWN);
        end else if (c.opcode == OP_REMOVE) begin
            idx = ent_slot[e];
            p = tbl_payload[idx];
            ent_live[e] = 1'b0;
            if (idx >= boundary) begin
                if (idx != occupied - 1) shift_entry(occupied - 1, idx);
            end else begin
                if (idx != boundary - 1) shift_entry(boundary - 1, idx);
                if (boundary != occupied) shift_entry(occupied - 1, boundary - 1);
                boundary--;
            end
            occupied--;
            push_beat(KIND_DONE, e, 0, idx, p, ST_OK);
        end else begin
            idx = ent_slot[e];
            p = tbl_payload[idx];
            fin = idx;
            if (!c.sleeping && idx >= boundary) begin
                fin = boundary;
                if (idx != fin) begin
                    shift_entry(fin, idx);
                    put_entry(e, p, fin);
                    push_beat(KIND_RELOC, e, idx, fin, p, ST_OK);
                end
                boundary++;
            end else if (c.sleeping && idx < boundary) begin
                fin = boundary - 1;
                if (idx != fin) begin
                    shift_entry(fin, idx);
                    put_entry(e, p, fin);
                    push_beat(KIND_RELOC, e, idx, fin, p, ST_OK);
                end
                boundary--;
            end
            push_beat(KIND_DONE, e, 0, fin, p, ST_OK);
        end
        foreach (op_beats[k]) begin
            op_beats[k].entry_count = occupied[COUNT_W-1:0];
            op_beats[k].awake_count = boundary[COUNT_W-1:0];
            op_beats[k].last = (k == op_beats.size() - 1);
            expected_beats.push_back(op_beats[k]);
        end
    endfunction

    initial begin
        fail_count = 0;
        occupied = 0;
        boundary = 0;
        foreach (ent_live[i]) ent_live[i] = 1'b0;
    end

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch("unexpected beat", o_res, '0);
                end else begin
                    want = expected_beats.pop_front();
                    if (o_res.kind != want.kind) report_mismatch("kind", o_res, want);
                    if (o_res.moved_entity != want.moved_entity)
                        report_mismatch("moved_entity", o_res, want);
                    if (o_res.from_slot != want.from_slot)
                        report_mismatch("from_slot", o_res, want);
                    if (o_res.to_slot != want.to_slot) report_mismatch("to_slot", o_res, want);
                    if (o_res.moved_payload != want.moved_payload)
                        report_mismatch("moved_payload", o_res, want);
                    if (o_res.status != want.status) report_mismatch("status", o_res, want);
                    if (o_res.entry_count != want.entry_count)
                        report_mismatch("entry_count", o_res, want);
                    if (o_res.awake_count != want.awake_count)
                        report_mismatch("awake_count", o_res, want);
                    if (o_res.last != want.last) report_mismatch("last", o_res, want);
                end
            end
            if (start && !busy) apply_command(i_cmd);
        end
    end

endmodule

/* sim/partitioned_packed_slot_table_top_test.sv */
`timescale 1ns / 100ps

module partitioned_packed_slot_table_top_test import ppst_pkg::*;;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_cmd i_cmd;
    logic o_valid;
    t_res o_res;
    int   fail_count;
    int   pending_count;

    logic [ENT_W-1:0] live_ids [$];
    logic             idle_enable;

    partitioned_packed_slot_table_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    partitioned_packed_slot_table_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .o_valid       (o_valid),
        .o_res         (o_res),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Sends one command beat and tracks which ids are live for later picks.
    task automatic send_cmd(input logic [1:0] op, input logic [ENT_W-1:0] ent,
                            input logic slp, input logic [PAY_W-1:0] pay);
        int gap;
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            gap = $urandom_range(1, 7);
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= '{opcode: op, entity_id: ent, sleeping: slp, payload: pay};
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        // Start drops once busy has fallen, before the block can take the same
        // command a second time.
        start <= 1'b0;
        @(posedge i_clk);
        if (op == OP_ADD && !(ent inside {live_ids}) && live_ids.size() < 1024)
            live_ids.push_back(ent);
        if (op == OP_REMOVE) begin
            foreach (live_ids[k]) begin
                if (live_ids[k] == ent) begin
                    live_ids.delete(k);
                    break;
                end
            end
        end
    endtask

    function automatic logic [PAY_W-1:0] rand_pay();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [ENT_W-1:0] pick_live();
        return live_ids[$urandom_range(0, live_ids.size() - 1)];
    endfunction

    initial begin
        int r;
        logic [1:0] op;
        start = 1'b0;
        i_cmd = '0;
        i_rst_n = 1'b0;
        idle_enable = 1'b1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: errors on an empty table, group moves, extremes of fields.
        send_cmd(OP_REMOVE, 12'd5, 1'b0, '0);
        send_cmd(OP_SET, 12'd5, 1'b1, '0);
        send_cmd(OP_NONE, 12'hFFF, 1'b1, '1);
        send_cmd(OP_ADD, 12'd0, 1'b1, '1);
        send_cmd(OP_ADD, 12'hFFF, 1'b1, 64'h0123_4567_89AB_CDEF);
        send_cmd(OP_ADD, 12'd7, 1'b0, '0);
        send_cmd(OP_ADD, 12'd8, 1'b0, 64'hFEDC_BA98_7654_3210);
        send_cmd(OP_ADD, 12'd7, 1'b0, '1);
        send_cmd(OP_SET, 12'd7, 1'b0, '0);
        send_cmd(OP_SET, 12'hFFF, 1'b0, '0);
        send_cmd(OP_SET, 12'd7, 1'b1, '0);
        send_cmd(OP_ADD, 12'd9, 1'b0, 64'h5555_AAAA_5555_AAAA);
        send_cmd(OP_REMOVE, 12'd9, 1'b0, '0);
        send_cmd(OP_REMOVE, 12'd0, 1'b0, '0);
        send_cmd(OP_REMOVE, 12'd8, 1'b0, '0);
        send_cmd(OP_REMOVE, 12'd8, 1'b0, '0);
        send_cmd(OP_NONE, 12'd0, 1'b0, '0);

        // Hold off until every expected beat has drained.
        while (pending_count != 0) @(posedge i_clk);

        for (int n = 0; n < 270; n++) begin
            if (n > 230) idle_enable = 1'b0;
            r = $urandom_range(0, 99);
            if (live_ids.size() == 0 || r < 40) op = OP_ADD;
            else if (r < 65) op = OP_REMOVE;
            else if (r < 95) op = OP_SET;
            else op = OP_NONE;
            if (op != OP_ADD && live_ids.size() != 0 && $urandom_range(0, 9) != 0)
                send_cmd(op, pick_live(), 1'($urandom()), rand_pay());
            else if (op == OP_ADD && live_ids.size() != 0 && $urandom_range(0, 15) == 0)
                send_cmd(op, pick_live(), 1'($urandom()), rand_pay());
            else
                send_cmd(op, 12'($urandom()), 1'($urandom()), rand_pay());
        end

        while (pending_count != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("partitioned_packed_slot_table_top_test passed");
        end else begin
            $display("partitioned_packed_slot_table_top_test failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("partitioned_packed_slot_table_top_test failed");
        $finish;
    end

endmodule
